[hdl/tkaf_pkg.sv]
`timescale 1ns / 1ps
package tkaf_pkg;
    localparam int MAX_CONNECTIONS_DEF = 64;
    localparam int CFG_W = 64;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PORT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIG0   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIG1   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIG2   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DIG3   = 3'd5;

    localparam logic [2:0] RSN_UNPROT   = 3'd0;
    localparam logic [2:0] RSN_KNOWN    = 3'd1;
    localparam logic [2:0] RSN_KNOCK_OK = 3'd2;
    localparam logic [2:0] RSN_KNOCK_BAD= 3'd3;
    localparam logic [2:0] RSN_UNAUTH   = 3'd4;
    localparam logic [2:0] RSN_OUT_REM  = 3'd5;
    localparam logic [2:0] RSN_OUT_UNK  = 3'd6;
    localparam logic [2:0] RSN_OUT_PASS = 3'd7;

    // table entry: family, port, address
    localparam int ENT_W = 1 + 16 + 64 + 64;

    typedef struct packed {
        logic req_type;
        logic is_ipv6;
        logic flag_syn;
        logic flag_ack;
        logic flag_rst;
        logic flag_fin;
        logic [15:0] peer_port;
        logic [15:0] local_port;
        logic [63:0] peer_addr_high;
        logic [63:0] peer_addr_low;
        logic [31:0] seq_number;
    } t_in_word;

    typedef struct packed {
        logic       accept;
        logic [2:0] reason;
    } t_out_word;

    // controller to datapath
    typedef struct packed {
        logic load;       // latch input word, reset scan
        logic scan_step;  // compare one slot
        logic hash_start; // load message and init state
        logic hash_step;  // one sha round
        logic wr_entry;   // write the free slot
        logic clr_match;  // invalidate matched slot
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_done;
        logic found;
        logic hash_done;
        logic knock_ok;
        logic have_free;
    } t_sts;

    localparam logic [31:0] SHA_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
        32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
        32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
        32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
        32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
        32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
        32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
        32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
        32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
        32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
        32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction
endpackage

[hdl/tkaf_if.sv]
`timescale 1ns / 1ps
interface tkaf_in_if import tkaf_pkg::*;;
    logic     valid;
    logic     ready;
    t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tkaf_out_if import tkaf_pkg::*;;
    logic      valid;
    logic      ready;
    t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[hdl/tkaf_ram.sv]
`timescale 1ns / 1ps
module tkaf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[hdl/tkaf_datapath.sv]
`timescale 1ns / 1ps
module tkaf_datapath import tkaf_pkg::*; #(
    parameter int MAX_CONNECTIONS = MAX_CONNECTIONS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_in_word            i_word,
    input  logic [255:0]        i_digest,
    input  logic                i_tbl_clr,
    input  t_cmd                i_cmd,
    output t_sts                o_sts,
    output t_in_word            o_word
);
    localparam int AW = (MAX_CONNECTIONS > 1) ? $clog2(MAX_CONNECTIONS) : 1;
    localparam int CW = $clog2(MAX_CONNECTIONS + 1);

    t_in_word r_word;
    logic [MAX_CONNECTIONS-1:0] r_valid;
    logic [CW-1:0] r_scan;      // slot address issued to ram
    logic          r_cmp_vld;   // compare pending for r_cmp_idx
    logic [AW-1:0] r_cmp_idx;
    logic          r_found;
    logic [AW-1:0] r_match;
    logic          r_have_free;
    logic [AW-1:0] r_free;
    logic [ENT_W-1:0] w_rdata;
    logic [ENT_W-1:0] w_key;
    logic [AW-1:0] w_raddr;

    // normalized key: ipv4 keeps low 32 bits only
    always_comb begin
        w_key = {r_word.is_ipv6, r_word.peer_port,
                 r_word.is_ipv6 ? r_word.peer_addr_high : 64'd0,
                 r_word.is_ipv6 ? r_word.peer_addr_low
                                : {32'd0, r_word.peer_addr_low[31:0]}};
    end

    assign w_raddr = r_scan[AW-1:0];

    tkaf_ram #(.WIDTH(ENT_W), .DEPTH(MAX_CONNECTIONS)) u_tbl (
        .i_clk  (i_clk),
        .i_we   (i_cmd.wr_entry),
        .i_waddr(r_free),
        .i_wdata(w_key),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    // input word latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_word <= i_word;
        end
    end

    // table scan: lowest match and lowest free slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= '0;
            r_cmp_vld <= 1'b0;
            r_found <= 1'b0;
            r_have_free <= 1'b0;
        end else if (i_cmd.load) begin
            r_scan <= '0;
            r_cmp_vld <= 1'b0;
            r_found <= 1'b0;
            r_have_free <= 1'b0;
        end else if (i_cmd.scan_step) begin
            r_cmp_vld <= (r_scan < CW'(MAX_CONNECTIONS));
            r_cmp_idx <= w_raddr;
            if (r_scan < CW'(MAX_CONNECTIONS)) begin
                r_scan <= r_scan + 1'b1;
            end
            if (r_cmp_vld) begin
                if (r_valid[r_cmp_idx] && w_rdata == w_key && !r_found) begin
                    r_found <= 1'b1;
                    r_match <= r_cmp_idx;
                end
                if (!r_valid[r_cmp_idx] && !r_have_free) begin
                    r_have_free <= 1'b1;
                    r_free <= r_cmp_idx;
                end
            end
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_tbl_clr) begin
            r_valid <= '0;
        end else if (i_cmd.clr_match) begin
            r_valid[r_match] <= 1'b0;
        end else if (i_cmd.wr_entry) begin
            r_valid[r_free] <= 1'b1;
        end
    end

    // sha-256 round unit
    logic [31:0] r_h [8];
    logic [31:0] r_w [16];
    logic [6:0]  r_rnd;
    logic [511:0] w_msg;
    logic [31:0] w_wt, w_t1, w_t2, w_s0, w_s1;

    always_comb begin
        w_msg = '0;
        w_msg[511:256] = i_digest;
        w_msg[255:240] = {r_word.peer_port[7:0], r_word.peer_port[15:8]};
        w_msg[239:224] = {r_word.local_port[7:0], r_word.local_port[15:8]};
        if (r_word.is_ipv6) begin
            w_msg[223:96] = {r_word.peer_addr_high, r_word.peer_addr_low};
            w_msg[95:88] = 8'h80;
            w_msg[63:0] = 64'd416;
        end else begin
            w_msg[223:192] = {r_word.peer_addr_low[7:0], r_word.peer_addr_low[15:8],
                              r_word.peer_addr_low[23:16], r_word.peer_addr_low[31:24]};
            w_msg[191:184] = 8'h80;
            w_msg[63:0] = 64'd320;
        end
    end

    always_comb begin
        w_s0 = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        w_s1 = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        w_wt = (r_rnd < 7'd16) ? r_w[0] : (r_w[0] + w_s0 + r_w[9] + w_s1);
        w_t1 = r_h[7] + (rotr(r_h[4], 6) ^ rotr(r_h[4], 11) ^ rotr(r_h[4], 25))
             + ((r_h[4] & r_h[5]) ^ (~r_h[4] & r_h[6])) + SHA_K[r_rnd[5:0]] + w_wt;
        w_t2 = (rotr(r_h[0], 2) ^ rotr(r_h[0], 13) ^ rotr(r_h[0], 22))
             + ((r_h[0] & r_h[1]) ^ (r_h[0] & r_h[2]) ^ (r_h[1] & r_h[2]));
    end

    // schedule window rotates by one word per round
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rnd <= '0;
        end else if (i_cmd.hash_start) begin
            r_rnd <= '0;
            for (int i = 0; i < 8; i++) r_h[i] <= SHA_INIT[i];
            for (int i = 0; i < 16; i++) r_w[i] <= w_msg[511-32*i -: 32];
        end else if (i_cmd.hash_step && r_rnd < 7'd64) begin
            r_rnd <= r_rnd + 1'b1;
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= w_wt;
            r_h[7] <= r_h[6]; r_h[6] <= r_h[5]; r_h[5] <= r_h[4];
            r_h[4] <= r_h[3] + w_t1;
            r_h[3] <= r_h[2]; r_h[2] <= r_h[1]; r_h[1] <= r_h[0];
            r_h[0] <= w_t1 + w_t2;
        end
    end

    assign o_sts.scan_done = (r_scan == CW'(MAX_CONNECTIONS)) && !r_cmp_vld;
    assign o_sts.found     = r_found;
    assign o_sts.have_free = r_have_free;
    assign o_sts.hash_done = (r_rnd == 7'd64);
    assign o_sts.knock_ok  = (r_h[0] + SHA_INIT[0]) == r_word.seq_number;
    assign o_word = r_word;
endmodule

[hdl/tkaf_ctrl.sv]
`timescale 1ns / 1ps
module tkaf_ctrl import tkaf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_word  o_out_data,
    input  logic       i_enable,
    input  logic [15:0] i_hidden_port,
    input  t_in_word   i_word,
    input  t_sts       i_sts,
    output t_cmd       o_cmd
);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_HASH = 5'b00100,
        S_DONE = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    t_out_word r_res, n_res;
    logic w_prot, w_rf;

    assign w_prot = i_enable && (i_word.local_port == i_hidden_port);
    assign w_rf = i_word.flag_rst || i_word.flag_fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_res <= n_res;
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_res = r_res;
        o_cmd = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (!w_prot) begin
                    n_res = t_out_word'{1'b1, RSN_UNPROT};
                    n_state = S_OUT;
                end else if (i_word.req_type && !w_rf) begin
                    n_res = t_out_word'{1'b1, RSN_OUT_PASS};
                    n_state = S_OUT;
                end else if (!i_sts.scan_done) begin
                    o_cmd.scan_step = 1'b1;
                end else if (i_word.req_type) begin
                    o_cmd.clr_match = i_sts.found;
                    n_res = i_sts.found ? t_out_word'{1'b1, RSN_OUT_REM}
                                        : t_out_word'{1'b0, RSN_OUT_UNK};
                    n_state = S_OUT;
                end else if (i_sts.found) begin
                    o_cmd.clr_match = w_rf;
                    n_res = t_out_word'{1'b1, RSN_KNOWN};
                    n_state = S_OUT;
                end else if (i_word.flag_syn && !i_word.flag_ack) begin
                    o_cmd.hash_start = 1'b1;
                    n_state = S_HASH;
                end else begin
                    n_res = t_out_word'{1'b0, RSN_UNAUTH};
                    n_state = S_OUT;
                end
            end
            S_HASH: begin
                o_cmd.hash_step = 1'b1;
                if (i_sts.hash_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_cmd.wr_entry = i_sts.knock_ok && i_sts.have_free;
                n_res = i_sts.knock_ok ? t_out_word'{1'b1, RSN_KNOCK_OK}
                                       : t_out_word'{1'b0, RSN_KNOCK_BAD};
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_out_valid = (r_state == S_OUT);
    assign o_out_data = r_res;
endmodule

[hdl/tcp_knock_authorization_filter.sv]
`timescale 1ns / 1ps
// channel    dir  word
// s_in       in   t_in_word: packet header fields
// m_out      out  t_out_word: accept, reason
// cfg        in   i_cfg_we / i_cfg_index / i_cfg_wdata
// one word at a time; unprotected or plain outbound words skip the table scan,
// other words scan the whole table, and a SYN knock then runs the 64 rounds
// of the single sha-256 round unit
// synchronous active-low reset clears state and configuration registers and empties the peer table
// a stalled result holds in the output register; input waits meanwhile
module tcp_knock_authorization_filter import tkaf_pkg::*; #(
    parameter int MAX_CONNECTIONS = MAX_CONNECTIONS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    tkaf_in_if.sink              s_in,
    tkaf_out_if.source           m_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_wdata
);
    logic         r_enable;
    logic [15:0]  r_hidden_port;
    logic [255:0] r_digest;
    logic         w_tbl_clr;
    t_cmd         w_cmd;
    t_sts         w_sts;
    t_in_word     w_word;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_hidden_port <= '0;
            r_digest <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_ENABLE: r_enable <= i_cfg_wdata[0];
                REG_PORT:   r_hidden_port <= i_cfg_wdata[15:0];
                REG_DIG0:   r_digest[255:192] <= i_cfg_wdata;
                REG_DIG1:   r_digest[191:128] <= i_cfg_wdata;
                REG_DIG2:   r_digest[127:64] <= i_cfg_wdata;
                REG_DIG3:   r_digest[63:0] <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign w_tbl_clr = i_cfg_we && ((i_cfg_index == REG_ENABLE && !i_cfg_wdata[0])
                                    || i_cfg_index == REG_PORT);

    tkaf_datapath #(.MAX_CONNECTIONS(MAX_CONNECTIONS)) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_word   (s_in.data),
        .i_digest (r_digest),
        .i_tbl_clr(w_tbl_clr),
        .i_cmd    (w_cmd),
        .o_sts    (w_sts),
        .o_word   (w_word)
    );

    tkaf_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_in.valid),
        .o_in_ready   (s_in.ready),
        .o_out_valid  (m_out.valid),
        .i_out_ready  (m_out.ready),
        .o_out_data   (m_out.data),
        .i_enable     (r_enable),
        .i_hidden_port(r_hidden_port),
        .i_word       (w_word),
        .i_sts        (w_sts),
        .o_cmd        (w_cmd)
    );
endmodule

[hdl/tkaf_checker.sv]
`timescale 1ns / 1ps
module tkaf_checker import tkaf_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input t_out_word out_data
);
    // no new word while a result is pending
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> !in_ready) else $error("input taken with result pending");

    // result held while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed under stall");

    // drops only for bad knock, unauthorized or unknown outbound
    a_drop_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_data.accept |-> (out_data.reason == RSN_KNOCK_BAD
        || out_data.reason == RSN_UNAUTH || out_data.reason == RSN_OUT_UNK))
        else $error("drop with accepting reason");

    // an accepted word never produces a result on the next edge
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !out_valid) else $error("result too early");
endmodule

bind tcp_knock_authorization_filter tkaf_checker u_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .in_valid (s_in.valid),
    .in_ready (s_in.ready),
    .out_valid(m_out.valid),
    .out_ready(m_out.ready),
    .out_data (m_out.data)
);
